>>> design/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the proximity avoidance controller
// Mode and command codes, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int MAX_SENSORS_DEF = 24;
  localparam int SINE_DEPTH_DEF  = 256;

  // result queue depth, power of two
  localparam int RESULT_DEPTH = 8;
  localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);

  localparam logic [15:0] HOLD_TICKS_RST  = 16'd20;
  localparam logic [14:0] WHEEL_SPEED_RST = 15'd1280;
  localparam logic [15:0] DELTA_RST       = 16'd6554;
  localparam logic [15:0] TAN_ALPHA_RST   = 16'd11556;

  typedef enum logic [1:0] {
    MODE_MOVING   = 2'd0,
    MODE_WAITING  = 2'd1,
    MODE_TURNING  = 2'd2,
    MODE_ESCAPING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_STOP     = 2'd0,
    CMD_FORWARD  = 2'd1,
    CMD_SPIN_POS = 2'd2,
    CMD_SPIN_NEG = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_HOLD_TICKS  = 2'd0,
    REG_WHEEL_SPEED = 2'd1,
    REG_DELTA       = 2'd2,
    REG_TAN_ALPHA   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [14:0] wheel_speed;
    logic [15:0] delta;
    logic [15:0] tan_alpha;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    mode_t              mode_now;
  } result_t;

  // per-cycle events from the datapath towards the result queue
  typedef struct packed {
    logic push;
    logic drop;
  } core_evt_t;

endpackage

>>> design/pva_reading_if.sv
// ----------------------------------------------------------------------------
// pva_reading_if: proximity reading channel
// Valid/ready stream carrying one sensor reading per transaction.
// ----------------------------------------------------------------------------
interface pva_reading_if;
  logic               valid;
  logic               ready;
  logic        [15:0] reading_value;
  logic signed [15:0] reading_angle;
  logic               last_reading;

  modport source (output valid, reading_value, reading_angle, last_reading, input ready);
  modport sink (input valid, reading_value, reading_angle, last_reading, output ready);
endinterface

>>> design/pva_command_if.sv
// ----------------------------------------------------------------------------
// pva_command_if: wheel command channel
// Valid/ready stream carrying one wheel command per transaction.
// ----------------------------------------------------------------------------
interface pva_command_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic        [1:0]  mode_now;

  modport source (output valid, left_speed, right_speed, mode_now, input ready);
  modport sink (input valid, left_speed, right_speed, mode_now, output ready);
endinterface

>>> design/pva_core.sv
// ----------------------------------------------------------------------------
// pva_core: reading pipeline, vector accumulation and mode sequencer
// Sine lookup, scaling multiply, saturating sums, per-tick decision and
// direction tests, one reading per cycle with no back-pressure.
// ----------------------------------------------------------------------------
module pva_core #(
  parameter int MAX_SENSORS      = pva_pkg::MAX_SENSORS_DEF,
  parameter int SINE_TABLE_DEPTH = pva_pkg::SINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_take,
  input  logic        [15:0] in_value,
  input  logic        [15:0] in_angle,
  input  logic               in_last,
  input  pva_pkg::cfg_t      cfg,
  output pva_pkg::core_evt_t evt,
  output pva_pkg::result_t   res
);
  import pva_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int CNT_W = $clog2(MAX_SENSORS + 1);
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam logic signed [24:0] SAT_HI = 25'sd8388607;
  localparam logic signed [24:0] SAT_LO = -25'sd8388607;

  // sine table construction, evaluated at elaboration only
  function automatic logic signed [15:0] quarter_sine(longint unsigned t);
    longint unsigned x, x2, term, r;
    x    = (t * PI_Q30) >> 15;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    term = ONE_Q30 - ((x2 * term) >> 30) / 72;
    term = ONE_Q30 - ((x2 * term) >> 30) / 42;
    term = ONE_Q30 - ((x2 * term) >> 30) / 20;
    term = ONE_Q30 - ((x2 * term) >> 30) / 6;
    r    = (((x * term) >> 30) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return 16'(r);
  endfunction

  function automatic logic signed [15:0] phase_sine(logic [15:0] p);
    logic signed [15:0] m;
    m = quarter_sine(p[14] ? (64'd16384 - 64'(p[13:0])) : 64'(p[13:0]));
    return p[15] ? -m : m;
  endfunction

  function automatic logic signed [15:0] rom_entry(int k);
    longint unsigned phase;
    phase = (64'(k) * 64'd65536) / SINE_TABLE_DEPTH;
    return phase_sine(16'(phase));
  endfunction

  function automatic logic signed [23:0] sat_add(logic signed [23:0] a,
                                                 logic signed [17:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > SAT_HI) s = SAT_HI;
    if (s < SAT_LO) s = SAT_LO;
    return 24'(s);
  endfunction

  function automatic logic [22:0] mag23(logic signed [23:0] v);
    logic signed [23:0] n;
    n = -v;
    return v[23] ? n[22:0] : v[22:0];
  endfunction

  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = rom_entry(k);
  end

  // ---------------------------------------------------------------- stage 1
  logic [15:0]          cos_phase;
  logic [IDX_W+15:0]    sin_scaled, cos_scaled;
  logic [IDX_W-1:0]     sin_idx, cos_idx;
  logic [CNT_W-1:0]     seen_cnt;
  logic                 cnt_use;

  assign cos_phase  = in_angle + 16'd16384;
  assign sin_scaled = (IDX_W+16)'(in_angle) * (IDX_W+16)'(SINE_TABLE_DEPTH);
  assign cos_scaled = (IDX_W+16)'(cos_phase) * (IDX_W+16)'(SINE_TABLE_DEPTH);
  assign sin_idx    = sin_scaled[IDX_W+15:16];
  assign cos_idx    = cos_scaled[IDX_W+15:16];
  assign cnt_use    = seen_cnt < CNT_W'(MAX_SENSORS);

  logic               p1_valid, p1_last, p1_use, p1_over;
  logic [15:0]        p1_value;
  logic signed [15:0] p1_sin, p1_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      seen_cnt <= '0;
    end else begin
      p1_valid <= in_take;
      if (in_take) begin
        if (in_last) begin
          seen_cnt <= '0;
        end else if (cnt_use) begin
          seen_cnt <= seen_cnt + CNT_W'(1);
        end
      end
    end
    p1_value <= in_value;
    p1_last  <= in_last;
    p1_use   <= cnt_use;
    p1_over  <= in_value > cfg.delta;
    p1_sin   <= sine_rom[sin_idx];
    p1_cos   <= sine_rom[cos_idx];
  end

  // ---------------------------------------------------------------- stage 2
  logic [14:0]        cos_mag, sin_mag;
  logic [30:0]        prod_x, prod_y;
  logic signed [17:0] px_next, py_next;
  logic signed [15:0] cos_neg, sin_neg;

  assign cos_neg = -p1_cos;
  assign sin_neg = -p1_sin;
  assign cos_mag = p1_cos[15] ? cos_neg[14:0] : p1_cos[14:0];
  assign sin_mag = p1_sin[15] ? sin_neg[14:0] : p1_sin[14:0];
  assign prod_x  = 31'(p1_value) * 31'(cos_mag);
  assign prod_y  = 31'(p1_value) * 31'(sin_mag);
  // truncation towards zero: scale the magnitude, then apply the sign
  assign px_next = p1_cos[15] ? -$signed({2'b00, prod_x[30:15]})
                              :  $signed({2'b00, prod_x[30:15]});
  assign py_next = p1_sin[15] ? -$signed({2'b00, prod_y[30:15]})
                              :  $signed({2'b00, prod_y[30:15]});

  logic               p2_valid, p2_last, p2_use, p2_over;
  logic signed [17:0] p2_px, p2_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_last <= p1_last;
    p2_use  <= p1_use;
    p2_over <= p1_over;
    p2_px   <= px_next;
    p2_py   <= py_next;
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [23:0] sum_x, sum_y, sum_x_next, sum_y_next;
  logic               obstacle_seen, obst_next;
  mode_t              mode, mode_next;
  logic [15:0]        tick_count, tick_next;
  logic               tick_end, d_valid, d_drop, d_auto;
  cmd_t               d_cmd;

  assign sum_x_next = sat_add(sum_x, p2_use ? p2_px : 18'sd0);
  assign sum_y_next = sat_add(sum_y, p2_use ? p2_py : 18'sd0);
  assign obst_next  = obstacle_seen | (p2_use & p2_over);
  assign tick_end   = p2_valid & p2_last;

  always_comb begin
    mode_next = mode;
    tick_next = tick_count;
    d_valid   = 1'b0;
    d_drop    = 1'b0;
    d_auto    = 1'b0;
    d_cmd     = CMD_STOP;
    if (tick_end) begin
      if (mode != MODE_MOVING) begin
        if (tick_count < cfg.hold_ticks) begin
          tick_next = tick_count + 16'd1;
          d_valid   = 1'b1;
          unique case (mode)
            MODE_TURNING:  d_cmd = CMD_SPIN_POS;
            MODE_ESCAPING: d_cmd = CMD_FORWARD;
            default:       d_cmd = CMD_STOP;
          endcase
        end else begin
          mode_next = (mode == MODE_ESCAPING) ? MODE_MOVING : mode_t'(mode + 2'd1);
          tick_next = '0;
          d_drop    = 1'b1;
        end
      end else if (obst_next) begin
        mode_next = MODE_WAITING;
        tick_next = '0;
        d_drop    = 1'b1;
      end else begin
        d_valid = 1'b1;
        d_auto  = 1'b1;
      end
    end
  end

  assign evt.drop = d_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_MOVING;
      tick_count    <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      obstacle_seen <= 1'b0;
    end else begin
      mode       <= mode_next;
      tick_count <= tick_next;
      if (p2_valid) begin
        if (p2_last) begin
          sum_x         <= '0;
          sum_y         <= '0;
          obstacle_seen <= 1'b0;
        end else begin
          sum_x         <= sum_x_next;
          sum_y         <= sum_y_next;
          obstacle_seen <= obst_next;
        end
      end
    end
  end

  logic        p3_valid, p3_auto, p3_zero, p3_xpos, p3_pos;
  cmd_t        p3_cmd;
  mode_t       p3_mode;
  logic [22:0] p3_ax, p3_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= d_valid;
    end
    p3_auto <= d_auto;
    p3_cmd  <= d_cmd;
    p3_mode <= mode;
    p3_ax   <= mag23(sum_x_next);
    p3_ay   <= mag23(sum_y_next);
    p3_zero <= (sum_x_next == '0) && (sum_y_next == '0);
    p3_xpos <= sum_x_next > 24'sd0;
    p3_pos  <= (sum_y_next > 24'sd0) || ((sum_y_next == '0) && sum_x_next[23]);
  end

  // ---------------------------------------------------------------- stage 4
  logic        p4_valid, p4_auto, p4_zero, p4_xpos, p4_pos;
  cmd_t        p4_cmd;
  mode_t       p4_mode;
  logic [45:0] p4_xx, p4_yy;
  logic [38:0] p4_tx;
  logic [22:0] p4_ay;
  logic [31:0] p4_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_auto <= p3_auto;
    p4_cmd  <= p3_cmd;
    p4_mode <= p3_mode;
    p4_zero <= p3_zero;
    p4_xpos <= p3_xpos;
    p4_pos  <= p3_pos;
    p4_ay   <= p3_ay;
    p4_xx   <= 46'(p3_ax) * 46'(p3_ax);
    p4_yy   <= 46'(p3_ay) * 46'(p3_ay);
    p4_tx   <= 39'(cfg.tan_alpha) * 39'(p3_ax);
    p4_dd   <= 32'(cfg.delta) * 32'(cfg.delta);
  end

  // ------------------------------------------------------ command selection
  logic               shorter, in_cone;
  cmd_t               cmd_sel;
  logic signed [15:0] w_pos, w_neg;

  assign shorter = (47'(p4_xx) + 47'(p4_yy)) < 47'(p4_dd);
  assign in_cone = p4_zero || (p4_xpos && ({p4_ay, 16'd0} <= p4_tx));
  assign w_pos   = $signed({1'b0, cfg.wheel_speed});
  assign w_neg   = -w_pos;

  always_comb begin
    if (!p4_auto) begin
      cmd_sel = p4_cmd;
    end else if (in_cone && shorter) begin
      cmd_sel = CMD_FORWARD;
    end else if (p4_pos) begin
      cmd_sel = CMD_SPIN_POS;
    end else begin
      cmd_sel = CMD_SPIN_NEG;
    end
    unique case (cmd_sel)
      CMD_STOP: begin
        res.left_speed  = 16'sd0;
        res.right_speed = 16'sd0;
      end
      CMD_FORWARD: begin
        res.left_speed  = w_pos;
        res.right_speed = w_pos;
      end
      CMD_SPIN_POS: begin
        res.left_speed  = w_pos;
        res.right_speed = w_neg;
      end
      CMD_SPIN_NEG: begin
        res.left_speed  = w_neg;
        res.right_speed = w_pos;
      end
    endcase
    res.mode_now = p4_mode;
  end

  assign evt.push = p4_valid;

endmodule

>>> design/proximity_avoidance_fsm_top.sv
// ----------------------------------------------------------------------------
// proximity_avoidance_fsm_top: proximity obstacle avoidance controller
// Accepts proximity readings, issues at most one wheel command per control
// tick, with configuration registers and a result queue.
// ----------------------------------------------------------------------------
//  channel   | dir | transaction
//  ----------+-----+---------------------------------------------------------
//  reading   | in  | reading_value, reading_angle, last_reading
//  command   | out | left_speed, right_speed, mode_now (only at a tick's end)
//  cfg_*     | in  | cfg_index selects the register, written when cfg_wr_en
//
// one reading per cycle while reading.ready is high; a command is offered once
// its last reading has passed the lookup, scale, accumulate and square
// registers, then selection into the queue
// reset is synchronous and clears mode, counters, sums and the queue
// up to 8 commands wait in the queue; reading.ready falls only when 8 tick
// ends have been taken whose commands are not yet delivered or dropped
// ----------------------------------------------------------------------------
module proximity_avoidance_fsm_top #(
  parameter int MAX_SENSORS      = pva_pkg::MAX_SENSORS_DEF,
  parameter int SINE_TABLE_DEPTH = pva_pkg::SINE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pva_reading_if.sink       reading,
  pva_command_if.source     command,
  input  logic              cfg_wr_en,
  input  pva_pkg::cfg_reg_t cfg_index,
  input  logic [15:0]       cfg_wr_data
);
  import pva_pkg::*;

  localparam logic [RESULT_PTR_W:0] FILL_MAX = (RESULT_PTR_W+1)'(RESULT_DEPTH);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks  <= HOLD_TICKS_RST;
      cfg.wheel_speed <= WHEEL_SPEED_RST;
      cfg.delta       <= DELTA_RST;
      cfg.tan_alpha   <= TAN_ALPHA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HOLD_TICKS:  cfg.hold_ticks  <= cfg_wr_data;
        REG_WHEEL_SPEED: cfg.wheel_speed <= cfg_wr_data[14:0];
        REG_DELTA:       cfg.delta       <= cfg_wr_data;
        REG_TAN_ALPHA:   cfg.tan_alpha   <= cfg_wr_data;
      endcase
    end
  end

  logic      take, take_last, pop;
  core_evt_t evt;
  result_t   res;

  assign take      = reading.valid & reading.ready;
  assign take_last = take & reading.last_reading;

  pva_core #(
    .MAX_SENSORS      (MAX_SENSORS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_take  (take),
    .in_value (reading.reading_value),
    .in_angle (reading.reading_angle),
    .in_last  (reading.last_reading),
    .cfg      (cfg),
    .evt      (evt),
    .res      (res)
  );

  // result queue
  result_t                 queue [RESULT_DEPTH];
  logic [RESULT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RESULT_PTR_W:0]   fill, fill_next;
  // slots owed to tick ends already taken
  logic [RESULT_PTR_W:0]   pending, pending_next;

  assign pop          = command.valid & command.ready;
  assign fill_next    = fill + (RESULT_PTR_W+1)'(evt.push) - (RESULT_PTR_W+1)'(pop);
  assign pending_next = pending + (RESULT_PTR_W+1)'(take_last)
                      - (RESULT_PTR_W+1)'(pop) - (RESULT_PTR_W+1)'(evt.drop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      pending <= '0;
    end else begin
      fill    <= fill_next;
      pending <= pending_next;
      if (evt.push) begin
        wr_ptr <= wr_ptr + RESULT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RESULT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.push) begin
      queue[wr_ptr] <= res;
    end
  end

  assign reading.ready       = pending < FILL_MAX;
  assign command.valid       = fill != '0;
  assign command.left_speed  = queue[rd_ptr].left_speed;
  assign command.right_speed = queue[rd_ptr].right_speed;
  assign command.mode_now    = queue[rd_ptr].mode_now;

`ifndef NO_ASSERTIONS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    evt.push |-> (fill < FILL_MAX || pop))
    else $error("result pushed into a full queue");

  a_credit_covers_queue: assert property (@(posedge clk) disable iff (rst)
    pending >= fill)
    else $error("queue holds more results than were reserved");

  a_drop_has_credit: assert property (@(posedge clk) disable iff (rst)
    evt.drop |-> pending != '0)
    else $error("tick end dropped without a reserved slot");
`endif

endmodule
